// ----- rtl/dd_pkg.sv -----
// ----------------------------------------------------------------------------
// dd_pkg
// shared widths, calendar tables and stage control types for the
// date difference pipeline
// ----------------------------------------------------------------------------
package dd_pkg;

	localparam int DAY_W     = 5;
	localparam int MONTH_W   = 4;
	localparam int YEAR_W    = 14;
	localparam int SERIAL_W  = 23;   // serial day number of a 14-bit year
	localparam int ELAPSED_W = 22;
	localparam int MPART_W   = 9;    // day plus earlier months, at most 366
	localparam int PROD_W    = 25;   // 12-bit quarter year times reciprocal
	localparam int QUOT_W    = 8;    // year / 100, at most 163
	localparam int QYEAR_W   = 12;   // year / 4

	localparam logic [12:0]  RECIP_25     = 13'd5243;  // 2^17 / 25, rounded up
	localparam int           RECIP_SHIFT  = 17;
	localparam logic [11:0]  QUARTERS_100 = 12'd25;    // quarter years per century
	localparam logic [8:0]   DAYS_YEAR    = 9'd365;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	// clock enables of the three stages inside one date converter
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

	// days in the earlier months of a common year
	function automatic logic [MPART_W-1:0] cum_days(input logic [MONTH_W-1:0] month);
		logic [MPART_W-1:0] days;
		case (month)
			4'd1:    days = 9'd0;
			4'd2:    days = 9'd31;
			4'd3:    days = 9'd59;
			4'd4:    days = 9'd90;
			4'd5:    days = 9'd120;
			4'd6:    days = 9'd151;
			4'd7:    days = 9'd181;
			4'd8:    days = 9'd212;
			4'd9:    days = 9'd243;
			4'd10:   days = 9'd273;
			4'd11:   days = 9'd304;
			4'd12:   days = 9'd334;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

	// month length in a common year, zero for a month that does not exist
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month);
		logic [DAY_W-1:0] len;
		case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                         len = 5'd28;
			default:                                      len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

// ----- rtl/date_difference_days.sv -----
// ----------------------------------------------------------------------------
// date_difference_days
// days elapsed between two proleptic gregorian dates, four-stage pipeline
// ----------------------------------------------------------------------------
// Each input transfer carries a start date and an end date as day, month and
// year. Both are turned into serial day numbers (day, plus earlier months of
// the year, plus 365*(y-1) + (y-1)/4 - (y-1)/100 + (y-1)/400) and the result
// is end minus start, 0 when the end does not come after the start, and
// saturated at 4194303. A month outside 1..12, a day of 0 or past the month's
// end, or a year of 0 sets invalid_date and forces elapsed_days to 0. The
// block takes one transfer per clock while s_axis_tready is high and returns one
// result transfer for each, in order, through four register stages (products
// and table lookups, quotients and year sum, serial number, difference).
// Every stage holds its own valid bit and advances whenever it is empty or the
// stage behind it moves, so bubbles are squeezed out and a back-pressured
// result does not block new input while earlier stages still have room.
// ----------------------------------------------------------------------------
module date_difference_days (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// start_day[4:0], start_month[8:5], start_year[22:9],
	// end_day[27:23], end_month[31:28], end_year[45:32], zero pad [47:46]
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// elapsed_days[21:0], zero pad [23:22]
	output logic [23:0] m_axis_tdata,
	// invalid_date[0]
	output logic        m_axis_tuser
);

	// unpack the input transfer
	logic [dd_pkg::DAY_W-1:0]   start_day;
	logic [dd_pkg::MONTH_W-1:0] start_month;
	logic [dd_pkg::YEAR_W-1:0]  start_year;
	logic [dd_pkg::DAY_W-1:0]   end_day;
	logic [dd_pkg::MONTH_W-1:0] end_month;
	logic [dd_pkg::YEAR_W-1:0]  end_year;

	assign start_day   = s_axis_tdata[4:0];
	assign start_month = s_axis_tdata[8:5];
	assign start_year  = s_axis_tdata[22:9];
	assign end_day     = s_axis_tdata[27:23];
	assign end_month   = s_axis_tdata[31:28];
	assign end_year    = s_axis_tdata[45:32];

	// valid bits, one per stage, the last one is the output register
	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic              valid_s4;
	dd_pkg::stage_en_t en;
	logic              en_s4;

	// a stage loads when it is empty or its contents move on this cycle
	assign en_s4 = !valid_s4 || m_axis_tready;
	assign en.s3 = !valid_s3 || en_s4;
	assign en.s2 = !valid_s2 || en.s3;
	assign en.s1 = !valid_s1 || en.s2;

	assign s_axis_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= s_axis_tvalid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	// one converter per date, both advance in lockstep
	logic [dd_pkg::SERIAL_W-1:0] serial_start_s3;
	logic [dd_pkg::SERIAL_W-1:0] serial_end_s3;
	logic                        ok_start_s3;
	logic                        ok_end_s3;

	dd_serial u_serial_start (
		.clk       (clk),
		.en        (en),
		.day       (start_day),
		.month     (start_month),
		.year      (start_year),
		.serial_s3 (serial_start_s3),
		.ok_s3     (ok_start_s3)
	);

	dd_serial u_serial_end (
		.clk       (clk),
		.en        (en),
		.day       (end_day),
		.month     (end_month),
		.year      (end_year),
		.serial_s3 (serial_end_s3),
		.ok_s3     (ok_end_s3)
	);

	// difference and output register
	logic [dd_pkg::ELAPSED_W-1:0] elapsed_s4;
	logic                         invalid_s4;

	dd_diff u_diff (
		.clk          (clk),
		.en           (en_s4),
		.serial_start (serial_start_s3),
		.ok_start     (ok_start_s3),
		.serial_end   (serial_end_s3),
		.ok_end       (ok_end_s3),
		.elapsed_s4   (elapsed_s4),
		.invalid_s4   (invalid_s4)
	);

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = {2'b00, elapsed_s4};
	assign m_axis_tuser  = invalid_s4;

endmodule

// ----- rtl/dd_serial.sv -----
// ----------------------------------------------------------------------------
// dd_serial
// three-stage converter from day, month and year to a serial day number,
// with the calendar validity check
// ----------------------------------------------------------------------------
module dd_serial (
	input  logic                             clk,
	input  dd_pkg::stage_en_t                en,
	input  logic [dd_pkg::DAY_W-1:0]         day,
	input  logic [dd_pkg::MONTH_W-1:0]       month,
	input  logic [dd_pkg::YEAR_W-1:0]        year,
	output logic [dd_pkg::SERIAL_W-1:0]      serial_s3,
	output logic                             ok_s3
);

	// stage 1: year - 1, reciprocal products, table lookups
	logic [dd_pkg::YEAR_W-1:0]   year_m1;
	logic [dd_pkg::YEAR_W-1:0]   year_m1_s1;
	logic [dd_pkg::PROD_W-1:0]   prod_p_s1;
	logic [dd_pkg::PROD_W-1:0]   prod_y_s1;
	logic [dd_pkg::QYEAR_W-1:0]  qyear_s1;
	logic                        y4_s1;
	logic                        year_zero_s1;
	logic [dd_pkg::SERIAL_W-1:0] p365_s1;
	logic                        month_ok_s1;
	logic                        is_feb_s1;
	logic                        after_feb_s1;
	logic [dd_pkg::MPART_W-1:0]  cum_s1;
	logic [dd_pkg::DAY_W-1:0]    mlen_s1;
	logic [dd_pkg::DAY_W-1:0]    day_s1;

	assign year_m1 = year - dd_pkg::YEAR_W'(1);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			year_m1_s1   <= year_m1;
			prod_p_s1    <= dd_pkg::PROD_W'(year_m1[dd_pkg::YEAR_W-1:2])
			                * dd_pkg::PROD_W'(dd_pkg::RECIP_25);
			prod_y_s1    <= dd_pkg::PROD_W'(year[dd_pkg::YEAR_W-1:2])
			                * dd_pkg::PROD_W'(dd_pkg::RECIP_25);
			qyear_s1     <= year[dd_pkg::YEAR_W-1:2];
			y4_s1        <= (year[1:0] == 2'd0);
			year_zero_s1 <= (year == '0);
			p365_s1      <= dd_pkg::SERIAL_W'(year_m1) * dd_pkg::SERIAL_W'(dd_pkg::DAYS_YEAR);
			month_ok_s1  <= (month >= dd_pkg::MONTH_JAN) && (month <= dd_pkg::MONTH_DEC);
			is_feb_s1    <= (month == dd_pkg::MONTH_FEB);
			after_feb_s1 <= (month > dd_pkg::MONTH_FEB);
			cum_s1       <= dd_pkg::cum_days(month);
			mlen_s1      <= dd_pkg::month_len(month);
			day_s1       <= day;
		end
	end

	// stage 2: quotients, leap year, earlier-years sum, in-year part
	logic [dd_pkg::QUOT_W-1:0]   q100;
	logic [dd_pkg::QUOT_W-1:0]   qy100;
	logic [dd_pkg::QYEAR_W-1:0]  qyear_mod25;
	logic                        leap;
	logic [dd_pkg::DAY_W-1:0]    day_lim;
	logic [dd_pkg::SERIAL_W-1:0] year_sum_s2;
	logic [dd_pkg::MPART_W-1:0]  mpart_s2;
	logic                        ok_s2;

	always_comb begin
		q100        = prod_p_s1[dd_pkg::RECIP_SHIFT +: dd_pkg::QUOT_W];
		qy100       = prod_y_s1[dd_pkg::RECIP_SHIFT +: dd_pkg::QUOT_W];
		qyear_mod25 = qyear_s1 - dd_pkg::QYEAR_W'(qy100) * dd_pkg::QUARTERS_100;
		// divisible by 4, and not a century unless the century divides by 4
		leap        = y4_s1 && ((qyear_mod25 != '0) || (qy100[1:0] == 2'd0));
		day_lim     = mlen_s1 + dd_pkg::DAY_W'(is_feb_s1 && leap);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			year_sum_s2 <= p365_s1
			               + dd_pkg::SERIAL_W'(year_m1_s1[dd_pkg::YEAR_W-1:2])
			               - dd_pkg::SERIAL_W'(q100)
			               + dd_pkg::SERIAL_W'(q100[dd_pkg::QUOT_W-1:2]);
			mpart_s2    <= dd_pkg::MPART_W'(day_s1) + cum_s1
			               + dd_pkg::MPART_W'(leap && after_feb_s1);
			ok_s2       <= !year_zero_s1 && month_ok_s1 && (day_s1 != '0)
			               && (day_s1 <= day_lim);
		end
	end

	// stage 3: serial day number
	always_ff @(posedge clk) begin
		if (en.s3) begin
			serial_s3 <= year_sum_s2 + dd_pkg::SERIAL_W'(mpart_s2);
			ok_s3     <= ok_s2;
		end
	end

endmodule

// ----- rtl/dd_diff.sv -----
// ----------------------------------------------------------------------------
// dd_diff
// output stage: clamped, saturated difference of two serial day numbers
// ----------------------------------------------------------------------------
module dd_diff (
	input  logic                              clk,
	input  logic                              en,
	input  logic [dd_pkg::SERIAL_W-1:0]       serial_start,
	input  logic                              ok_start,
	input  logic [dd_pkg::SERIAL_W-1:0]       serial_end,
	input  logic                              ok_end,
	output logic [dd_pkg::ELAPSED_W-1:0]      elapsed_s4,
	output logic                              invalid_s4
);

	logic [dd_pkg::SERIAL_W-1:0]  diff;
	logic [dd_pkg::ELAPSED_W-1:0] elapsed;

	always_comb begin
		diff = serial_end - serial_start;
		if (!ok_start || !ok_end || (serial_end <= serial_start)) begin
			elapsed = '0;
		end else if (diff[dd_pkg::SERIAL_W-1]) begin
			elapsed = dd_pkg::ELAPSED_MAX;
		end else begin
			elapsed = diff[dd_pkg::ELAPSED_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			elapsed_s4 <= elapsed;
			invalid_s4 <= !(ok_start && ok_end);
		end
	end

endmodule

// ----- rtl/dd_checker.sv -----
// ----------------------------------------------------------------------------
// dd_checker
// port-level assertions for date_difference_days, bound to the top level
// ----------------------------------------------------------------------------
module dd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
	else $error("result transfer dropped while stalled");

	// an invalid date always reports zero days
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0)
	else $error("invalid date with nonzero elapsed days");

	// with the output register empty nothing can block the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
	else $error("input stalled while output is empty");

	// an accepted pair reaches the output within the pipeline depth,
	// or the output is already occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> ##4 m_axis_tvalid)
	else $error("accepted transfer did not reach the output");

endmodule

bind date_difference_days dd_checker u_dd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ----- verif/date_difference_days_checker.sv -----
// ----------------------------------------------------------------------------
// date_difference_days_checker
// predicts elapsed days for every accepted date pair and compares the results
// ----------------------------------------------------------------------------
module date_difference_days_checker
	import dd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        m_tuser,
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// one input transfer, lowest field in the lowest bits
	typedef struct packed {
		logic [1:0]         pad;
		logic [YEAR_W-1:0]  end_year;
		logic [MONTH_W-1:0] end_month;
		logic [DAY_W-1:0]   end_day;
		logic [YEAR_W-1:0]  start_year;
		logic [MONTH_W-1:0] start_month;
		logic [DAY_W-1:0]   start_day;
	} date_pair_t;

	typedef struct {
		date_pair_t             pair;
		logic [ELAPSED_W-1:0]   elapsed_days;
		logic                   invalid_date;
	} day_count_t;

	day_count_t elapsed_q[$];

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	function automatic logic is_leap(input logic [YEAR_W-1:0] year);
		return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
	endfunction

	function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
			input logic leap);
		case (month)
			1, 3, 5, 7, 8, 10, 12: return 5'd31;
			4, 6, 9, 11:           return 5'd30;
			MONTH_FEB:             return leap ? 5'd29 : 5'd28;
			default:               return 5'd0;
		endcase
	endfunction

	// serial day number counted from 0001-01-01 as day 1, zero flag if not a date
	function automatic logic serial_of(input logic [DAY_W-1:0] day,
			input logic [MONTH_W-1:0] month, input logic [YEAR_W-1:0] year,
			output logic [SERIAL_W-1:0] serial);
		logic               leap;
		logic [MONTH_W-1:0] mm;
		logic [SERIAL_W-1:0] prior;
		logic [SERIAL_W-1:0] total;
		serial = '0;
		leap   = is_leap(year);
		if (year == 0 || month < MONTH_JAN || month > MONTH_DEC || day == 0 ||
				day > days_in(month, leap))
			return 1'b0;
		total = SERIAL_W'(day);
		for (mm = MONTH_JAN; mm < month; mm++)
			total += SERIAL_W'(days_in(mm, leap));
		prior  = SERIAL_W'(year - 1'b1);
		total += SERIAL_W'(DAYS_YEAR * prior + prior / 4 - prior / 100 + prior / 400);
		serial = total;
		return 1'b1;
	endfunction

	function automatic day_count_t predict_elapsed(input date_pair_t pair);
		logic                ok_start;
		logic                ok_end;
		logic [SERIAL_W-1:0] start_serial;
		logic [SERIAL_W-1:0] end_serial;
		day_count_t          res;
		ok_start = serial_of(pair.start_day, pair.start_month, pair.start_year, start_serial);
		ok_end   = serial_of(pair.end_day, pair.end_month, pair.end_year, end_serial);
		res.pair         = pair;
		res.elapsed_days = '0;
		res.invalid_date = 1'b1;
		if (ok_start && ok_end) begin
			res.invalid_date = 1'b0;
			if (end_serial > start_serial) begin
				if (end_serial - start_serial > ELAPSED_MAX)
					res.elapsed_days = ELAPSED_MAX;
				else
					res.elapsed_days = ELAPSED_W'(end_serial - start_serial);
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin : watch
		date_pair_t pair;
		day_count_t want;
		string      dates;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				pair = s_tdata;
				elapsed_q.insert(elapsed_q.size(), predict_elapsed(pair));
			end
			if (m_tvalid && m_tready) begin
				if (elapsed_q.size() == 0) begin
					report_mismatch($sformatf("result transfer with no date pair waiting: %0d/%0b",
						m_tdata[ELAPSED_W-1:0], m_tuser));
				end else begin
					want  = elapsed_q.pop_front();
					dates = $sformatf("%0d-%0d-%0d to %0d-%0d-%0d",
						want.pair.start_year, want.pair.start_month, want.pair.start_day,
						want.pair.end_year, want.pair.end_month, want.pair.end_day);
					if (m_tdata[ELAPSED_W-1:0] !== want.elapsed_days)
						report_mismatch($sformatf("%s: elapsed_days %0d, expected %0d",
							dates, m_tdata[ELAPSED_W-1:0], want.elapsed_days));
					if (m_tuser !== want.invalid_date)
						report_mismatch($sformatf("%s: invalid_date %b, expected %b",
							dates, m_tuser, want.invalid_date));
					if (m_tdata[23:ELAPSED_W] !== '0)
						report_mismatch($sformatf("%s: pad bits %b not zero",
							dates, m_tdata[23:ELAPSED_W]));
				end
			end
			pending = elapsed_q.size();
		end
	end

endmodule

// ----- verif/date_difference_days_tb.sv -----
// ----------------------------------------------------------------------------
// date_difference_days_tb
// stream-level test of the date difference pipeline
// ----------------------------------------------------------------------------
// Feeds date pairs through the input stream: a short directed set on the
// calendar corners (leap rules, bad months and days, year zero, years past
// 9999, saturation), then random pairs weighted toward real dates, with
// random gaps on the input side and random stalls on the output side. The
// checker beside the block predicts each result and counts mismatches; this
// module only drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module date_difference_days_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dd_pkg::*;

	localparam int RANDOM_PAIRS = 1450;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 16;     // a few times the depth of the four-stage pipeline
	localparam int RESET_CYCLES = 11;
	localparam int MODE_SPAN    = 150;    // pairs per idling regime

	// how hard each side idles during a stretch of the run
	typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// start_day[4:0], start_month[8:5], start_year[22:9],
	// end_day[27:23], end_month[31:28], end_year[45:32], zero pad [47:46]
	logic [47:0] s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// elapsed_days[21:0], zero pad [23:22]
	logic [23:0] m_axis_tdata;
	// invalid_date[0]
	logic        m_axis_tuser;

	int          mismatches;
	int          pending;
	int          cycle_count = 0;
	int          stall_left  = 0;
	idle_mode_t  send_mode   = IDLE_NONE;
	idle_mode_t  recv_mode   = IDLE_NONE;

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	date_difference_days dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	date_difference_days_checker day_count_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tuser    (m_axis_tuser),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// gap length: mostly zero or short, now and then a long one
	function automatic int idle_cycles(input idle_mode_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			IDLE_LIGHT: begin
				if (r < 75)      return 0;
				else if (r < 97) return $urandom_range(1, 3);
				else             return $urandom_range(10, 40);
			end
			IDLE_HEAVY: begin
				if (r < 40)      return 0;
				else if (r < 88) return $urandom_range(1, 4);
				else             return $urandom_range(10, 60);
			end
			default: return 0;
		endcase
	endfunction

	// one date pair per transfer, valid held until accepted
	task automatic send_dates(
		input logic [DAY_W-1:0]   sd, input logic [MONTH_W-1:0] sm, input logic [YEAR_W-1:0] sy,
		input logic [DAY_W-1:0]   ed, input logic [MONTH_W-1:0] em, input logic [YEAR_W-1:0] ey
	);
		int gap;
		gap = idle_cycles(send_mode);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  = {2'b00, ey, em, ed, sy, sm, sd};
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// a date in the given year range, days past 28 now and then so that
	// short months and common-year februaries overflow
	task automatic pick_date(input int year_lo, input int year_hi,
		output logic [DAY_W-1:0] d, output logic [MONTH_W-1:0] m, output logic [YEAR_W-1:0] y);
		y = YEAR_W'($urandom_range(year_lo, year_hi));
		m = MONTH_W'($urandom_range(MONTH_JAN, MONTH_DEC));
		if ($urandom_range(0, 3) == 0)
			d = DAY_W'($urandom_range(29, 31));
		else
			d = DAY_W'($urandom_range(1, 28));
	endtask

	// output side stalls, changes at the falling edge
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready = 1'b0;
			stall_left--;
		end else begin
			m_axis_tready = 1'b1;
			stall_left    = idle_cycles(recv_mode);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		logic [DAY_W-1:0]   sd, ed;
		logic [MONTH_W-1:0] sm, em;
		logic [YEAR_W-1:0]  sy, ey;
		int                 kind;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed corners, no idling
		send_dates(1, 1, 1,        1, 1, 1);          // same day
		send_dates(1, 1, 1,        31, 12, 9999);     // full four-digit span
		send_dates(31, 12, 9999,   1, 1, 1);          // end before start
		send_dates(28, 2, 2000,    29, 2, 2000);      // leap day, divisible by 400
		send_dates(29, 2, 2000,    1, 3, 2000);
		send_dates(29, 2, 1900,    1, 3, 1900);       // century is not leap
		send_dates(29, 2, 1600,    29, 2, 2400);
		send_dates(29, 2, 2001,    1, 1, 2002);       // common year has no feb 29
		send_dates(29, 2, 2100,    1, 1, 2101);
		send_dates(1, 0, 2020,     1, 1, 2021);       // month zero
		send_dates(1, 1, 2020,     1, 13, 2021);      // month past december
		send_dates(31, 15, 16383,  1, 1, 1);          // every start field all ones
		send_dates(0, 1, 2020,     1, 1, 2020);       // day zero
		send_dates(1, 1, 2020,     31, 4, 2020);      // day past a 30-day month
		send_dates(31, 12, 2020,   31, 1, 2021);
		send_dates(1, 1, 0,        1, 1, 1);          // year zero on either side
		send_dates(1, 1, 1,        1, 1, 0);
		send_dates(0, 0, 0,        0, 0, 0);
		send_dates(1, 1, 1,        31, 12, 16383);    // saturates the output
		send_dates(31, 12, 9999,   1, 1, 10000);      // years past 9999 stay valid
		send_dates(1, 1, 10000,    31, 12, 16383);
		send_dates(2, 3, 2024,     1, 3, 2024);       // one day backward
		send_dates(31, 1, 1,       1, 2, 1);          // month boundary
		send_dates(30, 11, 2023,   31, 7, 2025);

		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			// fresh idling regime for each stretch, the first one idling heavily on both sides
			if (n % MODE_SPAN == 0) begin
				send_mode = (n == 0) ? IDLE_HEAVY : idle_mode_t'($urandom_range(0, 2));
				recv_mode = (n == 0) ? IDLE_HEAVY : idle_mode_t'($urandom_range(0, 2));
			end
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				// unrelated four-digit dates, either order
				pick_date(1, 9999, sd, sm, sy);
				pick_date(1, 9999, ed, em, ey);
			end else if (kind < 70) begin
				// nearby dates, small differences and near misses
				pick_date(1, 9999, sd, sm, sy);
				pick_date(1, 9999, ed, em, ey);
				ey = sy + YEAR_W'($urandom_range(0, 1));
			end else if (kind < 85) begin
				// long spans reaching past 9999, many of them saturating
				pick_date(1, 2500, sd, sm, sy);
				pick_date(9000, 16383, ed, em, ey);
			end else begin
				// raw field bits, mostly not dates
				sd = DAY_W'($urandom_range(0, 31));
				sm = MONTH_W'($urandom_range(0, 15));
				sy = YEAR_W'($urandom_range(0, 16383));
				ed = DAY_W'($urandom_range(0, 31));
				em = MONTH_W'($urandom_range(0, 15));
				ey = YEAR_W'($urandom_range(0, 16383));
			end
			send_dates(sd, sm, sy, ed, em, ey);
		end
		@(negedge clk);
		s_axis_tvalid = 1'b0;

		// drain, then let the pipeline settle so stray results get caught
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- date_difference_days.f -----
rtl/dd_pkg.sv
rtl/dd_serial.sv
rtl/dd_diff.sv
rtl/date_difference_days.sv
rtl/dd_checker.sv
verif/date_difference_days_checker.sv
verif/date_difference_days_tb.sv
